// ----- hw/rtl/jse_pkg.sv -----
// ============================================================================
// jse_pkg
// Shared types, character codes and text formatting for the JSON escaper.
// ============================================================================
package jse_pkg;

	localparam int MaxSlots = 4;
	localparam int QDepth   = 2;
	localparam int QAw      = $clog2(QDepth);

	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CTRL_TOP = 8'h20;
	localparam logic [7:0] LEAD2_LO = 8'hC2;
	localparam logic [7:0] LEAD2_HI = 8'hDF;
	localparam logic [7:0] LEAD3_LO = 8'hE0;
	localparam logic [7:0] LEAD3_HI = 8'hEF;
	localparam logic [7:0] LEAD4_LO = 8'hF0;
	localparam logic [7:0] LEAD4_HI = 8'hF4;
	localparam logic [7:0] CONT_LO  = 8'h80;
	localparam logic [7:0] CONT_HI  = 8'hBF;

	typedef enum logic [1:0] {
		K_LIT,
		K_PAIR,
		K_UESC,
		K_SEQ
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} slot_t;

	typedef struct packed {
		slot_t [MaxSlots-1:0] slots;
		logic [2:0]           count;
		logic [31:0]          seq_text;
		logic [2:0]           seq_len;
		logic                 last;
	} bundle_t;

	typedef struct packed {
		logic [47:0] text;
		logic [2:0]  len;
	} text_t;

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h57 + {4'h0, v});
	endfunction

	function automatic text_t format_slot(input slot_t s, input logic [31:0] seq_text,
			input logic [2:0] seq_len);
		text_t r;
		r = '0;
		case (s.kind)
			K_LIT: begin
				r.text = {40'h0, s.data};
				r.len  = 3'd1;
			end
			K_PAIR: begin
				r.text = {32'h0, s.data, CH_BSL};
				r.len  = 3'd2;
			end
			K_UESC: begin
				r.text = {hex_char(s.data[3:0]), hex_char(s.data[7:4]),
					CH_ZERO, CH_ZERO, CH_U, CH_BSL};
				r.len  = 3'd6;
			end
			default: begin
				r.text = {16'h0, seq_text};
				r.len  = seq_len;
			end
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/jse_front.sv -----
// ============================================================================
// jse_front
// Accepts bytes, tracks open UTF-8 sequences and builds a bundle of results.
// ============================================================================
module jse_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	input  logic             full,
	output logic             push,
	output jse_pkg::bundle_t push_data
);
	import jse_pkg::*;

	logic       seq_open_q;
	logic [7:0] held_lead_q;
	logic [7:0] held_conts_q [2];
	logic [1:0] held_count_q;
	logic [2:0] seq_length_q;

	logic       accept;
	logic       is_cont;
	logic [2:0] lead_len;
	logic       complete;
	logic       flush;
	logic       extra_uesc;
	logic       hold_cont;
	logic       fresh;
	logic       opens;
	bundle_t    b;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;
	assign is_cont  = (in_byte >= CONT_LO) && (in_byte <= CONT_HI);

	always_comb begin
		if (in_byte >= LEAD2_LO && in_byte <= LEAD2_HI) begin
			lead_len = 3'd2;
		end else if (in_byte >= LEAD3_LO && in_byte <= LEAD3_HI) begin
			lead_len = 3'd3;
		end else if (in_byte >= LEAD4_LO && in_byte <= LEAD4_HI) begin
			lead_len = 3'd4;
		end else begin
			lead_len = 3'd0;
		end
	end

	assign complete   = seq_open_q && is_cont && (({1'b0, held_count_q} + 3'd2) >= seq_length_q);
	assign flush      = seq_open_q && !complete && (!is_cont || in_last);
	assign extra_uesc = seq_open_q && is_cont && !complete && in_last;
	assign hold_cont  = seq_open_q && is_cont && !complete && !in_last;
	assign fresh      = !seq_open_q || !is_cont;

	always_comb begin
		b          = '0;
		b.last     = in_last;
		b.seq_len  = {1'b0, held_count_q} + 3'd2;
		opens      = 1'b0;
		case (held_count_q)
			2'd0:    b.seq_text = {16'h0, in_byte, held_lead_q};
			2'd1:    b.seq_text = {8'h0, in_byte, held_conts_q[0], held_lead_q};
			default: b.seq_text = {in_byte, held_conts_q[1], held_conts_q[0], held_lead_q};
		endcase
		if (complete) begin
			b.slots[0] = '{kind: K_SEQ, data: in_byte};
			b.count    = 3'd1;
		end
		if (flush) begin
			b.slots[0] = '{kind: K_UESC, data: held_lead_q};
			b.slots[1] = '{kind: K_UESC, data: held_conts_q[0]};
			b.slots[2] = '{kind: K_UESC, data: held_conts_q[1]};
			b.count    = {1'b0, held_count_q} + 3'd1;
		end
		if (extra_uesc) begin
			b.slots[b.count[1:0]] = '{kind: K_UESC, data: in_byte};
			b.count               = b.count + 3'd1;
		end
		if (fresh) begin
			case (in_byte)
				CH_BSL:   b.slots[b.count[1:0]] = '{kind: K_PAIR, data: CH_BSL};
				CH_QUOTE: b.slots[b.count[1:0]] = '{kind: K_PAIR, data: CH_QUOTE};
				CH_LF:    b.slots[b.count[1:0]] = '{kind: K_PAIR, data: CH_N};
				CH_CR:    b.slots[b.count[1:0]] = '{kind: K_PAIR, data: CH_R};
				CH_TAB:   b.slots[b.count[1:0]] = '{kind: K_PAIR, data: CH_T};
				default: begin
					if (in_byte < CTRL_TOP) begin
						b.slots[b.count[1:0]] = '{kind: K_UESC, data: in_byte};
					end else if (in_byte < CONT_LO) begin
						b.slots[b.count[1:0]] = '{kind: K_LIT, data: in_byte};
					end else if (lead_len == 3'd0 || in_last) begin
						b.slots[b.count[1:0]] = '{kind: K_UESC, data: in_byte};
					end else begin
						opens = 1'b1;
					end
				end
			endcase
			if (!opens) begin
				b.count = b.count + 3'd1;
			end
		end
	end

	assign push      = accept && (b.count != 3'd0);
	assign push_data = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_open_q   <= 1'b0;
			held_lead_q  <= '0;
			held_count_q <= '0;
			seq_length_q <= '0;
		end else if (accept) begin
			if (opens) begin
				seq_open_q   <= 1'b1;
				held_lead_q  <= in_byte;
				held_count_q <= '0;
				seq_length_q <= lead_len;
			end else if (complete || flush) begin
				seq_open_q   <= 1'b0;
				held_lead_q  <= '0;
				held_count_q <= '0;
				seq_length_q <= '0;
			end else if (hold_cont) begin
				held_count_q <= held_count_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold_cont) begin
			held_conts_q[held_count_q[0]] <= in_byte;
		end
	end

endmodule

// ----- hw/rtl/jse_queue.sv -----
// ============================================================================
// jse_queue
// Short bundle queue between the classifying front and the output back end.
// ============================================================================
module jse_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jse_pkg::bundle_t push_data,
	input  logic             pop,
	output jse_pkg::bundle_t head,
	output logic             empty,
	output logic             full
);
	import jse_pkg::*;

	bundle_t        mem_q [QDepth];
	logic [QAw-1:0] wr_ptr_q;
	logic [QAw-1:0] rd_ptr_q;
	logic [QAw:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == QDepth[QAw:0]);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAw'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAw'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- hw/rtl/jse_back.sv -----
// ============================================================================
// jse_back
// Walks head bundle results into the output reg, one per cycle unless stalled.
// ============================================================================
module jse_back (
	input  logic             clk,
	input  logic             arst_n,
	input  jse_pkg::bundle_t head,
	input  logic             empty,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [55:0]      m_tdata,
	output logic             m_tuser,
	output logic             m_tlast
);
	import jse_pkg::*;

	logic [1:0]  idx_q;
	logic        valid_q;
	logic [47:0] text_q;
	logic [2:0]  len_q;
	logic        run_last_q;
	logic        text_end_q;

	logic  load;
	logic  final_slot;
	text_t fmt;

	assign load       = !empty && (!valid_q || m_tready);
	assign final_slot = ({1'b0, idx_q} == (head.count - 3'd1));
	assign pop        = load && final_slot;
	assign fmt        = format_slot(head.slots[idx_q], head.seq_text, head.seq_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= final_slot ? 2'd0 : idx_q + 2'd1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			text_q     <= fmt.text;
			len_q      <= fmt.len;
			run_last_q <= final_slot;
			text_end_q <= final_slot && head.last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {5'h0, len_q, text_q};
	assign m_tuser  = run_last_q;
	assign m_tlast  = text_end_q;

endmodule

// ----- hw/rtl/json_string_escaper.sv -----
// ============================================================================
// json_string_escaper
// JSON string escaping with UTF-8 multi-byte pass-through.
// ============================================================================
// Bytes of a string enter on the s_ side, one per transaction, with s_tlast
// on the final byte. Each byte yields zero to four results on the m_ side:
// up to six characters of escaped text plus a length, run_last in m_tuser
// and end of string in m_tlast. Bytes of an incomplete UTF-8 sequence yield
// nothing until the sequence completes or breaks.
// A byte can be accepted every cycle while the queue is not full. The first
// result of a byte is written into the bundle queue and then loaded into the
// output register; the output register delivers one result per cycle while
// the receiver is ready, and a bundle leaves the queue with its last result.
// A two-entry bundle queue separates the front from the back; when the
// receiver stalls, the output holds, the queue fills and s_tready drops.
// Reset clears the open sequence, the queue and the output valid.
// ============================================================================
module json_string_escaper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // in_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [47:0] out_text, [50:48] out_len, rest zero
	output logic        m_tuser,   // run_last
	output logic        m_tlast    // text_end
);
	import jse_pkg::*;

	logic    push;
	logic    pop;
	logic    empty;
	logic    full;
	bundle_t push_data;
	bundle_t head;

	jse_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.full     (full),
		.push     (push),
		.push_data(push_data)
	);

	jse_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	jse_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
